>>> sv/txc_pkg.sv
`default_nettype none

package txc_pkg;

  // Screen geometry defaults.
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Field widths of the request and result transfers.
  localparam int REQ_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int ROW_W    = 5;
  localparam int COL_W    = 7;
  localparam int CURSOR_W = 11;
  localparam int CELL_W   = CHAR_W + ATTR_W;

  // Configuration port.
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;
  localparam int REG_TEXT_ATTR = 0;

  // Character codes and reset values.
  localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR   = 8'h0A;
  localparam logic [CHAR_W-1:0] BACKSPACE_CHAR = 8'h08;
  localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'h0F;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUT   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SCROLL,
    ST_BLANK,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

>>> sv/txc_req_if.sv
`default_nettype none

// Request channel: one console request per transfer.
interface txc_req_if;
  import txc_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [CHAR_W-1:0] char_code;
  logic [ROW_W-1:0]  cell_row;
  logic [COL_W-1:0]  cell_col;

  modport source (output valid, req_type, char_code, cell_row, cell_col, input ready);
  modport sink (input valid, req_type, char_code, cell_row, cell_col, output ready);
endinterface

`default_nettype wire

>>> sv/txc_rsp_if.sv
`default_nettype none

// Result channel: one result per request.
interface txc_rsp_if;
  import txc_pkg::*;

  logic                valid;
  logic                ready;
  logic [CURSOR_W-1:0] cursor_position;
  logic [CHAR_W-1:0]   cell_char;
  logic [ATTR_W-1:0]   cell_attr;
  logic                did_scroll;

  modport source (output valid, cursor_position, cell_char, cell_attr, did_scroll,
                  input ready);
  modport sink (input valid, cursor_position, cell_char, cell_attr, did_scroll,
                output ready);
endinterface

`default_nettype wire

>>> sv/txc_cell_mem.sv
`default_nettype none

// Character cell store: one write port, one read port, registered read data.
module txc_cell_mem #(
  parameter int DEPTH  = txc_pkg::COLUMNS_DEF * txc_pkg::ROWS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire                         clk_i,
  input  wire                         we_i,
  input  wire  [ADDR_W-1:0]           waddr_i,
  input  wire  [txc_pkg::CELL_W-1:0]  wdata_i,
  input  wire                         re_i,
  input  wire  [ADDR_W-1:0]           raddr_i,
  output logic [txc_pkg::CELL_W-1:0]  rdata_o
);
  import txc_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> sv/txc_cfg_regs.sv
`default_nettype none

// APB register block holding the text attribute.
module txc_cfg_regs (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [txc_pkg::PADDR_W-1:0]  paddr,
  input  wire  [txc_pkg::PDATA_W-1:0]  pwdata,
  output logic [txc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [txc_pkg::ATTR_W-1:0]   text_attr_o
);
  import txc_pkg::*;

  logic [ATTR_W-1:0] text_attr_q;
  logic [ATTR_W-1:0] text_attr_d;
  logic              hit_attr;

  // Word decode; the byte offset bits are ignored.
  assign hit_attr = (paddr[PADDR_W-1:2] == (PADDR_W-2)'(REG_TEXT_ATTR));

  always_comb begin
    text_attr_d = text_attr_q;
    if (psel && penable && pwrite && hit_attr) begin
      text_attr_d = pwdata[ATTR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_attr_q <= ATTR_RESET;
    end else begin
      text_attr_q <= text_attr_d;
    end
  end

  // Read data is returned in the access cycle.
  assign prdata      = hit_attr ? PDATA_W'(text_attr_q) : '0;
  assign pready      = 1'b1;
  assign text_attr_o = text_attr_q;

endmodule

`default_nettype wire

>>> sv/text_console_writer.sv
`default_nettype none

// A put, read or unused request goes to ST_DONE, where its result is registered once
// the result register is free. A put that scrolls first copies the rows up in ST_SCROLL
// and blanks the last row in ST_BLANK; a clear first sweeps the cell memory in ST_CLEAR.
// A new request is taken only after the result of the previous one has been loaded.
// Reset: after rst_ni is released, a sweep of the cell memory blanks every cell
// with attribute 0x0F before the first request is taken; register writes are taken.
module text_console_writer #(
  parameter int COLUMNS = txc_pkg::COLUMNS_DEF,
  parameter int ROWS    = txc_pkg::ROWS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  txc_req_if.sink                      req_i,
  txc_rsp_if.source                    rsp_o,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [txc_pkg::PADDR_W-1:0]  paddr,
  input  wire  [txc_pkg::PDATA_W-1:0]  pwdata,
  output logic [txc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import txc_pkg::*;

  localparam int CELLS     = COLUMNS * ROWS;
  localparam int LAST_BASE = COLUMNS * (ROWS - 1);
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int CCOL_W    = $clog2(COLUMNS);

  state_e state_q, state_d;

  logic [ADDR_W-1:0] cursor_q, cursor_d;
  logic [CCOL_W-1:0] col_q, col_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic              is_read_q, is_read_d;
  logic              oob_q, oob_d;
  logic              scroll_q, scroll_d;

  logic                rsp_valid_q, rsp_valid_d;
  logic [CURSOR_W-1:0] rsp_cursor_q, rsp_cursor_d;
  logic [CHAR_W-1:0]   rsp_char_q, rsp_char_d;
  logic [ATTR_W-1:0]   rsp_attr_q, rsp_attr_d;
  logic                rsp_scroll_q, rsp_scroll_d;

  logic [ATTR_W-1:0] text_attr;
  logic              in_fire;
  logic              rsp_load;
  logic              cnt_last;
  req_e              req;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, mem_rdata;

  logic [ADDR_W:0]   put_cursor;
  logic [CCOL_W-1:0] put_col;
  logic              put_we;
  logic [ADDR_W-1:0] put_waddr;
  logic [CELL_W-1:0] put_wdata;
  logic              put_wrap;
  logic              rd_oob;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W+CURSOR_W-1:0] cursor_ext;

  txc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .text_attr_o (text_attr)
  );

  txc_cell_mem #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_cell_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign req      = req_e'(req_i.req_type);
  assign in_fire  = req_i.valid && req_i.ready;
  assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp_o.ready);
  assign cnt_last = (cnt_q == ADDR_W'(CELLS - 1));

  // Put decode: cursor step, column step and the cell write for one character.
  always_comb begin
    put_cursor = {1'b0, cursor_q};
    put_col    = col_q;
    put_we     = 1'b0;
    put_waddr  = cursor_q;
    put_wdata  = {text_attr, req_i.char_code};
    priority if (req_i.char_code == NEWLINE_CHAR) begin
      put_cursor = {1'b0, cursor_q} + ((ADDR_W+1)'(COLUMNS) - (ADDR_W+1)'(col_q));
      put_col    = '0;
    end else if (req_i.char_code == BACKSPACE_CHAR) begin
      if (cursor_q != '0) begin
        put_cursor = {1'b0, cursor_q} - (ADDR_W+1)'(1);
        put_col    = (col_q == '0) ? CCOL_W'(COLUMNS - 1) : col_q - CCOL_W'(1);
        put_we     = 1'b1;
        put_waddr  = cursor_q - ADDR_W'(1);
        put_wdata  = {text_attr, BLANK_CHAR};
      end
    end else begin
      put_cursor = {1'b0, cursor_q} + (ADDR_W+1)'(1);
      put_col    = (col_q == CCOL_W'(COLUMNS - 1)) ? '0 : col_q + CCOL_W'(1);
      put_we     = 1'b1;
    end
    put_wrap = (put_cursor >= (ADDR_W+1)'(CELLS));
  end

  // Read address: row times the row length plus the column.
  always_comb begin
    rd_oob  = (int'(req_i.cell_row) >= ROWS) || (int'(req_i.cell_col) >= COLUMNS);
    rd_addr = ADDR_W'(int'(req_i.cell_row) * COLUMNS + int'(req_i.cell_col));
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (cnt_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          unique case (req)
            REQ_PUT:   state_d = put_wrap ? ST_SCROLL : ST_DONE;
            REQ_CLEAR: state_d = ST_CLEAR;
            REQ_READ:  state_d = ST_DONE;
            REQ_NONE:  state_d = ST_DONE;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (cnt_last) state_d = ST_DONE;
      end
      ST_SCROLL: begin
        if (cnt_q == ADDR_W'(LAST_BASE)) state_d = ST_BLANK;
      end
      ST_BLANK: begin
        if (cnt_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (rsp_load) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  // Memory control, cursor and request bookkeeping.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_q;
    mem_wdata = {text_attr, BLANK_CHAR};
    mem_re    = 1'b0;
    mem_raddr = rd_addr;
    cursor_d  = cursor_q;
    col_d     = col_q;
    cnt_d     = cnt_q;
    is_read_d = is_read_q;
    oob_d     = oob_q;
    scroll_d  = scroll_q;
    unique case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {ATTR_RESET, BLANK_CHAR};
        cnt_d     = cnt_q + ADDR_W'(1);
      end
      ST_IDLE: begin
        cnt_d = '0;
        if (in_fire) begin
          is_read_d = (req == REQ_READ);
          oob_d     = rd_oob;
          scroll_d  = 1'b0;
          unique case (req)
            REQ_PUT: begin
              mem_we    = put_we;
              mem_waddr = put_waddr;
              mem_wdata = put_wdata;
              if (put_wrap) begin
                cursor_d = ADDR_W'(LAST_BASE);
                col_d    = '0;
                scroll_d = 1'b1;
              end else begin
                cursor_d = put_cursor[ADDR_W-1:0];
                col_d    = put_col;
              end
            end
            REQ_READ: begin
              mem_re = !rd_oob;
            end
            REQ_CLEAR: begin
              cursor_d = '0;
              col_d    = '0;
            end
            REQ_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_CLEAR: begin
        mem_we = 1'b1;
        cnt_d  = cnt_q + ADDR_W'(1);
      end
      ST_SCROLL: begin
        // Read one row ahead and write the data back in the next cycle.
        mem_re    = (cnt_q != ADDR_W'(LAST_BASE));
        mem_raddr = cnt_q + ADDR_W'(COLUMNS);
        mem_we    = (cnt_q != '0);
        mem_waddr = cnt_q - ADDR_W'(1);
        mem_wdata = mem_rdata;
        if (cnt_q != ADDR_W'(LAST_BASE)) cnt_d = cnt_q + ADDR_W'(1);
      end
      ST_BLANK: begin
        mem_we = 1'b1;
        cnt_d  = cnt_q + ADDR_W'(1);
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Result stage.
  assign cursor_ext = (ADDR_W+CURSOR_W)'(cursor_q);

  always_comb begin
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_cursor_d = rsp_cursor_q;
    rsp_char_d   = rsp_char_q;
    rsp_attr_d   = rsp_attr_q;
    rsp_scroll_d = rsp_scroll_q;
    if (rsp_load) begin
      rsp_valid_d  = 1'b1;
      rsp_cursor_d = cursor_ext[CURSOR_W-1:0];
      rsp_char_d   = (is_read_q && !oob_q) ? mem_rdata[CHAR_W-1:0] : '0;
      rsp_attr_d   = (is_read_q && !oob_q) ? mem_rdata[CELL_W-1:CHAR_W] : '0;
      rsp_scroll_d = scroll_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cursor_q    <= '0;
      col_q       <= '0;
      cnt_q       <= '0;
      is_read_q   <= 1'b0;
      oob_q       <= 1'b0;
      scroll_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      col_q       <= col_d;
      cnt_q       <= cnt_d;
      is_read_q   <= is_read_d;
      oob_q       <= oob_d;
      scroll_q    <= scroll_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_cursor_q <= rsp_cursor_d;
    rsp_char_q   <= rsp_char_d;
    rsp_attr_q   <= rsp_attr_d;
    rsp_scroll_q <= rsp_scroll_d;
  end

  assign req_i.ready           = (state_q == ST_IDLE);
  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.cursor_position = rsp_cursor_q;
  assign rsp_o.cell_char       = rsp_char_q;
  assign rsp_o.cell_attr       = rsp_attr_q;
  assign rsp_o.did_scroll      = rsp_scroll_q;

  // The cursor always stays on the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni) int'(cursor_q) < CELLS)
    else $error("cursor left the screen");

  // Every cell write lands inside the store.
  assert property (@(posedge clk_i) disable iff (!rst_ni) mem_we |-> int'(mem_waddr) < CELLS)
    else $error("cell write out of range");

  // A cell is never read and written in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re && (mem_waddr == mem_raddr)))
    else $error("cell read and write collide");

  // A request is taken only once the previous one is finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_fire |=> !req_i.ready)
    else $error("request taken while busy");

  // A scrolled result always leaves the cursor at the start of the last row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && scroll_q) |-> cursor_q == ADDR_W'(LAST_BASE))
    else $error("scroll left the cursor off the last row");

endmodule

`default_nettype wire

>>> bench/console_scoreboard.sv
`default_nettype none

// Watches the request, result and register channels of the console writer.
// It keeps its own copy of the screen, cursor and text attribute, and checks
// every result transfer against the oldest prediction still waiting.
module console_scoreboard
  import txc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  txc_req_if                  req_mon,
  txc_rsp_if                  rsp_mon,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  input  logic                pready,
  output int                  fail_count,
  output int                  pending,
  output int                  scroll_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS     = COLUMNS_DEF * ROWS_DEF;
  localparam int LAST_ROW  = COLUMNS_DEF * (ROWS_DEF - 1);
  localparam int ATTR_ADDR = REG_TEXT_ATTR * 4;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_position;
    logic [CHAR_W-1:0]   cell_char;
    logic [ATTR_W-1:0]   cell_attr;
    logic                did_scroll;
  } console_result_t;

  // Shadow copy of the console state.
  logic [CELL_W-1:0] screen [CELLS];
  int                cursor;
  logic [ATTR_W-1:0] text_attr;

  console_result_t   expected_results [$];

  assign pending = expected_results.size();

  // Applies one request to the shadow screen and returns the result it should give.
  function automatic console_result_t apply_request(input req_e kind,
                                                    input logic [CHAR_W-1:0] ch,
                                                    input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
    console_result_t r;
    r = '0;
    case (kind)
      REQ_PUT: begin
        if (ch == NEWLINE_CHAR) begin
          cursor = (cursor / COLUMNS_DEF + 1) * COLUMNS_DEF;
        end else if (ch == BACKSPACE_CHAR) begin
          // Backspace at the home position leaves everything alone.
          if (cursor > 0) begin
            cursor = cursor - 1;
            screen[cursor] = {text_attr, BLANK_CHAR};
          end
        end else begin
          screen[cursor] = {text_attr, ch};
          cursor = cursor + 1;
        end
        // Running past the last cell moves every row up and blanks the last one.
        if (cursor >= CELLS) begin
          for (int i = 0; i < LAST_ROW; i++) screen[i] = screen[i + COLUMNS_DEF];
          for (int i = LAST_ROW; i < CELLS; i++) screen[i] = {text_attr, BLANK_CHAR};
          cursor = LAST_ROW;
          r.did_scroll = 1'b1;
        end
      end
      REQ_READ: begin
        // Cells outside the screen read back as zero.
        if (row < ROWS_DEF && col < COLUMNS_DEF) begin
          {r.cell_attr, r.cell_char} = screen[int'(row) * COLUMNS_DEF + int'(col)];
        end
      end
      REQ_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen[i] = {text_attr, BLANK_CHAR};
        cursor = 0;
      end
      default: begin
      end
    endcase
    r.cursor_position = CURSOR_W'(cursor);
    return r;
  endfunction

  // Results are checked before the request of the same edge is predicted, so a
  // stray result can never be matched against a prediction made on that edge.
  always @(posedge clk_i or negedge rst_ni) begin
    console_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < CELLS; i++) screen[i] = {ATTR_RESET, BLANK_CHAR};
      cursor = 0;
      text_attr = ATTR_RESET;
      expected_results.delete();
      fail_count = 0;
      scroll_count = 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no request waiting: cursor_position %0d",
                 rsp_mon.cursor_position);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (rsp_mon.did_scroll) scroll_count++;
          if (rsp_mon.cursor_position !== want.cursor_position) begin
            $error("cursor_position: expected %0d, got %0d",
                   want.cursor_position, rsp_mon.cursor_position);
            fail_count++;
          end
          if (rsp_mon.cell_char !== want.cell_char) begin
            $error("cell_char: expected 0x%02h, got 0x%02h",
                   want.cell_char, rsp_mon.cell_char);
            fail_count++;
          end
          if (rsp_mon.cell_attr !== want.cell_attr) begin
            $error("cell_attr: expected 0x%02h, got 0x%02h",
                   want.cell_attr, rsp_mon.cell_attr);
            fail_count++;
          end
          if (rsp_mon.did_scroll !== want.did_scroll) begin
            $error("did_scroll: expected %0b, got %0b", want.did_scroll, rsp_mon.did_scroll);
            fail_count++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        expected_results.push_back(apply_request(req_e'(req_mon.req_type), req_mon.char_code,
                                                 req_mon.cell_row, req_mon.cell_col));
      end
      if (psel && penable && pwrite && pready && int'(paddr) == ATTR_ADDR) begin
        text_attr = pwdata[ATTR_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

>>> bench/tb.sv
`default_nettype none

// Drives console requests and register writes into the console writer and
// reports the verdict from the scoreboard's failure count.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import txc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int fail_count;
  int pending;
  int scroll_count;

  // Idle control: when set, the side runs without any gaps.
  logic steady_source = 1'b0;
  logic steady_sink   = 1'b0;

  int put_count, read_count, clear_count, unused_count, setting_count;

  txc_req_if req_if ();
  txc_rsp_if rsp_if ();

  text_console_writer uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  console_scoreboard scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_if),
    .rsp_mon      (rsp_if),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count   (fail_count),
    .pending      (pending),
    .scroll_count (scroll_count)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_length();
    if ($urandom_range(0, 99) < 85) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  // Result side: random stalls on ready.
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!steady_sink && stall_left == 0 && $urandom_range(0, 99) < 30) begin
        stall_left = idle_length();
      end
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // One request transfer. Called and left just after a falling edge.
  task automatic send_request(input req_e kind, input logic [CHAR_W-1:0] ch,
                              input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    int gap;
    gap = 0;
    if (!steady_source && $urandom_range(0, 99) < 35) gap = idle_length();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.req_type  <= kind;
    req_if.char_code <= ch;
    req_if.cell_row  <= row;
    req_if.cell_col  <= col;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
    case (kind)
      REQ_PUT:   put_count++;
      REQ_READ:  read_count++;
      REQ_CLEAR: clear_count++;
      default:   unused_count++;
    endcase
  endtask

  // Put with random content in the fields a put does not use.
  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_request(REQ_PUT, ch, ROW_W'($urandom), COL_W'($urandom));
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_attr(input logic [ATTR_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(REG_TEXT_ATTR * 4);
    pwdata  <= {(PDATA_W - ATTR_W)'($urandom), value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    setting_count++;
  endtask

  // Blocks until every request has produced its result.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Random traffic built from short sequences: runs of text, backspaces,
  // newlines and reads, with some arbitrary requests and clears mixed in.
  task automatic run_traffic(input int quota);
    int start, kind, len;
    start = put_count + read_count + clear_count + unused_count;
    while (put_count + read_count + clear_count + unused_count - start < quota) begin
      kind = int'($urandom_range(0, 99));
      if (kind < 45) begin
        len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(60, 120))
                                          : int'($urandom_range(1, 30));
        repeat (len) put_char(CHAR_W'($urandom_range(0, 255)));
        if ($urandom_range(0, 4) == 0) put_char(NEWLINE_CHAR);
      end else if (kind < 55) begin
        repeat ($urandom_range(1, 6)) put_char(BACKSPACE_CHAR);
      end else if (kind < 75) begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 99) < 85) begin
            send_request(REQ_READ, CHAR_W'($urandom), ROW_W'($urandom_range(0, ROWS_DEF - 1)),
                         COL_W'($urandom_range(0, COLUMNS_DEF - 1)));
          end else begin
            send_request(REQ_READ, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
          end
        end
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 40)) put_char(NEWLINE_CHAR);
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 4)) begin
          send_request(req_e'($urandom_range(0, 3)), CHAR_W'($urandom), ROW_W'($urandom),
                       COL_W'($urandom));
        end
      end else if (kind < 93) begin
        send_request(REQ_CLEAR, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
      end else begin
        send_request(REQ_NONE, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
      end
    end
  endtask

  initial begin
    logic [ATTR_W-1:0] phase_attr [5];
    phase_attr[0] = 8'h00;
    phase_attr[1] = 8'hFF;
    phase_attr[2] = ATTR_W'($urandom);
    phase_attr[3] = ATTR_W'($urandom);
    phase_attr[4] = ATTR_RESET;

    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.req_type  = REQ_PUT;
    req_if.char_code = '0;
    req_if.cell_row  = '0;
    req_if.cell_col  = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, under the reset attribute.
    put_char(BACKSPACE_CHAR);
    send_request(REQ_PUT, 8'h00, 5'd31, 7'd127);
    send_request(REQ_PUT, 8'hFF, 5'd0, 7'd0);
    put_char(8'h41);
    put_char(BACKSPACE_CHAR);
    send_request(REQ_READ, 8'h00, 5'd0, 7'd0);
    send_request(REQ_READ, 8'hFF, 5'd0, 7'd1);
    send_request(REQ_READ, 8'h00, 5'd0, 7'd2);
    send_request(REQ_READ, 8'h00, 5'd24, 7'd79);
    send_request(REQ_READ, 8'h00, 5'd31, 7'd127);
    send_request(REQ_READ, 8'h00, 5'd25, 7'd0);
    send_request(REQ_READ, 8'h00, 5'd0, 7'd80);
    send_request(REQ_NONE, 8'hFF, 5'd31, 7'd127);
    // A newline on the last row scrolls the screen.
    repeat (ROWS_DEF) put_char(NEWLINE_CHAR);
    send_request(REQ_READ, 8'h00, 5'd0, 7'd1);
    put_char(8'h7E);
    send_request(REQ_CLEAR, 8'hFF, 5'd31, 7'd127);
    send_request(REQ_READ, 8'h00, 5'd0, 7'd0);

    // Random phases, each under its own attribute setting.
    for (int p = 0; p < 5; p++) begin
      drain();
      write_attr(phase_attr[p]);
      steady_source = (p == 3);
      steady_sink   = (p == 3);
      run_traffic(160);
    end
    drain();

    // Catch any late or extra result.
    repeat (2 * COLUMNS_DEF * ROWS_DEF + 100) @(posedge clk_i);
    $display("Ran %0d puts, %0d reads, %0d clears and %0d unused requests",
             put_count, read_count, clear_count, unused_count);
    $display("under %0d register settings; the screen scrolled %0d times.",
             setting_count + 1, scroll_count);
    if (fail_count == 0) begin
      $display("text_console_writer: match");
    end else begin
      $display("text_console_writer: mismatch");
    end
    $finish;
  end

  // Watchdog for a hung handshake or a result that never arrives.
  initial begin
    #20_000_000;
    $display("text_console_writer: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
sv/txc_pkg.sv
sv/txc_req_if.sv
sv/txc_rsp_if.sv
sv/txc_cell_mem.sv
sv/txc_cfg_regs.sv
sv/text_console_writer.sv
bench/console_scoreboard.sv
bench/tb.sv
